FILE: rtl/core/sitd_pkg.sv
package sitd_pkg;
    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    // Correct one BCD digit before the next shift.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] nib);
        logic [3:0] res;
        res = (nib >= 4'd5) ? nib + 4'd3 : nib;
        return res;
    endfunction
endpackage

FILE: rtl/core/sitd_bcd_pipe.sv
module sitd_bcd_pipe #(
    parameter int INPUT_WIDTH = 32,
    parameter int NDIG = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [INPUT_WIDTH-1:0] i_number,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic                   o_neg,
    output logic [NDIG*4-1:0]      o_bcd,
    input  logic                   i_ready
);
    localparam int NS = INPUT_WIDTH + 1;

    logic                   r_vld [0:NS-1];
    logic                   r_neg [0:NS-1];
    logic [INPUT_WIDTH-1:0] r_mag [0:NS-1];
    logic [NDIG*4-1:0]      r_bcd [0:NS-1];
    logic                   en;

    // the whole line advances together, bubbles included
    assign en      = !r_vld[NS-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_bcd   = r_bcd[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_neg[0] <= i_number[INPUT_WIDTH-1];
            r_mag[0] <= i_number[INPUT_WIDTH-1] ? (~i_number + 1'b1) : i_number;
            r_bcd[0] <= '0;
            for (int k = 1; k < NS; k++) begin
                logic [NDIG*4-1:0] adj;
                adj = '0;
                for (int d = 0; d < NDIG; d++)
                    adj[4*d +: 4] = sitd_pkg::bcd_adjust(r_bcd[k-1][4*d +: 4]);
                r_neg[k] <= r_neg[k-1];
                r_mag[k] <= {r_mag[k-1][INPUT_WIDTH-2:0], 1'b0};
                r_bcd[k] <= {adj[NDIG*4-2:0], r_mag[k-1][INPUT_WIDTH-1]};
            end
        end
    end
endmodule

FILE: rtl/core/sitd_ser.sv
module sitd_ser #(
    parameter int NDIG = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_neg,
    input  logic [NDIG*4-1:0] i_bcd,
    output logic              o_ready,
    output logic              o_valid,
    output logic [7:0]        o_char,
    output logic              o_last,
    input  logic              i_ready
);
    localparam int CW = $clog2(NDIG + 1);

    logic              r_busy, r_skip, r_neg, r_ovalid, r_last;
    logic [NDIG*4-1:0] r_dig;
    logic [CW-1:0]     r_cnt;
    logic [7:0]        r_char;
    logic [3:0]        top;
    logic              slot_free;
    logic              emit;

    assign top       = r_dig[NDIG*4-1 -: 4];
    assign slot_free = !r_ovalid || i_ready;
    assign emit      = r_busy && !r_skip && slot_free;
    assign o_ready   = !r_busy;
    assign o_valid   = r_ovalid;
    assign o_char    = r_char;
    assign o_last    = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && !emit) r_ovalid <= 1'b0;
            if (!r_busy) begin
                if (i_valid) begin
                    r_busy <= 1'b1;
                    r_skip <= 1'b1;
                    r_neg  <= i_neg;
                    r_dig  <= i_bcd;
                    r_cnt  <= CW'(NDIG);
                end
            end else if (r_skip) begin
                // drop leading zeros, keep at least one digit
                if (top == 4'd0 && r_cnt > CW'(1)) begin
                    r_dig <= r_dig << 4;
                    r_cnt <= r_cnt - 1'b1;
                end else begin
                    r_skip <= 1'b0;
                end
            end else if (slot_free) begin
                r_ovalid <= 1'b1;
                if (r_neg) begin
                    r_char <= sitd_pkg::ASCII_MINUS;
                    r_last <= 1'b0;
                    r_neg  <= 1'b0;
                end else begin
                    r_char <= sitd_pkg::ASCII_ZERO + {4'd0, top};
                    r_last <= (r_cnt == CW'(1));
                    r_dig  <= r_dig << 4;
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) r_busy <= 1'b0;
                end
            end
        end
    end
endmodule

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// A number passes through the binary-to-BCD register line into the serialiser,
// which removes leading zeros and then emits one character per cycle while the
// output is not stalled. The serialiser takes a new number only after its last
// character is sent; the BCD line stalls while its output waits.
// Reset: synchronous, active low; clears all valid bits and the serialiser's busy flag.
module signed_int_to_decimal_ascii #(
    parameter int INPUT_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((INPUT_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // [W-1:0] number
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // [7:0] char_code
    output logic                               m_axis_tlast
);
    localparam int NDIG = (INPUT_WIDTH * 3) / 10 + 1;

    logic              p_valid, p_neg, p_ready;
    logic [NDIG*4-1:0] p_bcd;

    sitd_bcd_pipe #(.INPUT_WIDTH(INPUT_WIDTH), .NDIG(NDIG)) u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_number (s_axis_tdata[INPUT_WIDTH-1:0]),
        .o_ready  (s_axis_tready),
        .o_valid  (p_valid),
        .o_neg    (p_neg),
        .o_bcd    (p_bcd),
        .i_ready  (p_ready)
    );

    sitd_ser #(.NDIG(NDIG)) u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (p_valid),
        .i_neg   (p_neg),
        .i_bcd   (p_bcd),
        .o_ready (p_ready),
        .o_valid (m_axis_tvalid),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .i_ready (m_axis_tready)
    );
endmodule

FILE: rtl/core/sitd_checker.sv
module sitd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("payload changed under stall");
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata == sitd_pkg::ASCII_MINUS ||
        (m_axis_tdata >= sitd_pkg::ASCII_ZERO && m_axis_tdata <= sitd_pkg::ASCII_ZERO + 8'd9))
        else $error("bad character");
    a_minus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata == sitd_pkg::ASCII_MINUS |-> !m_axis_tlast)
        else $error("sign flagged last");
endmodule

bind signed_int_to_decimal_ascii sitd_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
